// ----- hdl/ibcp_pkg.sv -----
// Package with shared constants, types and functions for the bearing unit.
`timescale 1ns / 1ps
`default_nettype none
package ibcp_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 20;
  localparam int CORDIC_STAGES_DEF   = 24;
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int BRG_W    = 29;
  localparam int SECT_W   = 4;
  localparam int BAM_W    = 32;
  localparam int DW       = 34;
  localparam int ZW       = 34;
  localparam int Q30_SHIFT = 30;
  localparam logic signed [DW-1:0] GAIN_Q30 = 34'sd652032875;
  localparam logic [BAM_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [BAM_W-1:0] QUARTER_TURN = 32'h4000_0000;

  typedef logic signed [DW-1:0] sval_t;

  function automatic logic [BAM_W-1:0] atan_bam(input logic [4:0] i);
    logic [BAM_W-1:0] r;
    case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ibcp_if.sv -----
// Valid/ready channel interfaces for positions in and bearings out.
`timescale 1ns / 1ps
`default_nettype none
interface ibcp_in_if;
  logic valid;
  logic ready;
  logic signed [27:0] from_lat;
  logic signed [28:0] from_lon;
  logic signed [27:0] to_lat;
  logic signed [28:0] to_lon;
  modport source (output valid, from_lat, from_lon, to_lat, to_lon, input ready);
  modport sink   (input valid, from_lat, from_lon, to_lat, to_lon, output ready);
endinterface

interface ibcp_out_if;
  logic valid;
  logic ready;
  logic [28:0] bearing;
  logic [3:0]  compass_sector;
  modport source (output valid, bearing, compass_sector, input ready);
  modport sink   (input valid, bearing, compass_sector, output ready);
endinterface
`default_nettype wire

// ----- hdl/ibcp_rot_cell.sv -----
// One rotation-mode CORDIC cell computing a sine/cosine stage.
`timescale 1ns / 1ps
`default_nettype none
module ibcp_rot_cell
  import ibcp_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire sval_t       x_in,
  input  wire sval_t       y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output sval_t            x_r,
  output sval_t            y_r,
  output logic signed [ZW-1:0] z_r
);
  localparam logic signed [ZW-1:0] ATN = ZW'(atan_bam(5'(STAGE)));
  sval_t xs, ys;
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_r <= x_in - ys;
        y_r <= y_in + xs;
        z_r <= z_in - ATN;
      end else begin
        x_r <= x_in + ys;
        y_r <= y_in - xs;
        z_r <= z_in + ATN;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ibcp_vec_cell.sv -----
// One vectoring-mode CORDIC cell for the atan2 chain.
`timescale 1ns / 1ps
`default_nettype none
module ibcp_vec_cell
  import ibcp_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire sval_t       x_in,
  input  wire sval_t       y_in,
  input  wire logic [BAM_W-1:0] z_in,
  output sval_t            x_r,
  output sval_t            y_r,
  output logic [BAM_W-1:0] z_r
);
  localparam logic [BAM_W-1:0] ATN = atan_bam(5'(STAGE));
  sval_t xs, ys;
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_r <= x_in + ys;
        y_r <= y_in - xs;
        z_r <= z_in + ATN;
      end else begin
        x_r <= x_in - ys;
        y_r <= y_in + xs;
        z_r <= z_in - ATN;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/initial_bearing_with_compass_point_unit.sv -----
// Top level: pipelined great-circle initial bearing with compass sector.
//
//  channel  | dir | signals
//  in_      | in  | valid, ready, from_lat, from_lon, to_lat, to_lon
//  out_     | out | valid, ready, bearing, compass_sector
//
// One position pair is taken every cycle while the output is not stalled;
// the steps are angle scaling, the sine/cosine cell row, four product
// stages, the atan2 cell row and bearing scaling.
// The whole pipeline advances only when its last stage is free; a stall
// on the output holds every stage. Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module initial_bearing_with_compass_point_unit
  import ibcp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ibcp_in_if.sink    in_ch,
  ibcp_out_if.source out_ch
);
  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 2 * N + 12;
  localparam int F   = ANGLE_FRAC_BITS;
  localparam logic [63:0] DEN = 64'(360) << F;
  // Reciprocal of 360 scaled by 2^RK; the product is brought back to units of 2^(32-F).
  localparam int RK  = 67 - F;
  localparam int RSH = RK - 32 + F;
  localparam logic [63:0] RECIP = (64'(1) << RK) / 64'(360) + 64'd1;
  localparam logic [BRG_W-1:0] FULL = BRG_W'(DEN);
  localparam logic [BRG_W-1:0] SECT = BRG_W'(64'(45) << F);

  logic [LAT-1:0] v_r;
  logic en;
  assign en = !v_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_ch.valid};
  end

  // Stage A: absolute magnitudes and signs.
  logic [30:0] mag_r [3];
  logic        neg_r [3];
  logic signed [30:0] raw [3];
  assign raw[0] = 31'(in_ch.from_lat);
  assign raw[1] = 31'(in_ch.to_lat);
  assign raw[2] = 31'(in_ch.to_lon) - 31'(in_ch.from_lon);
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= raw[k][30];
        mag_r[k] <= raw[k][30] ? 31'(-raw[k]) : 31'(raw[k]);
      end
    end
  end

  // Stage B: q = (mag*2^32 + DEN/2) / DEN by reciprocal product, then fixup.
  logic [95:0] prod_r [3];
  logic [63:0] num_r [3];
  logic        negb_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k]  <= (64'(mag_r[k]) << 32) + (DEN >> 1);
        prod_r[k] <= 96'(mag_r[k]) * 96'(RECIP);
        negb_r[k] <= neg_r[k];
      end
    end
  end

  // Stage C: quotient estimate, at most three below the true value, and its remainder.
  logic [63:0] qe [3];
  logic [63:0] qe_r [3];
  logic [63:0] re_r [3];
  logic        negc_r [3];
  always_comb begin
    for (int k = 0; k < 3; k++) qe[k] = 64'(prod_r[k] >> RSH) - 64'd2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        qe_r[k]   <= qe[k];
        re_r[k]   <= num_r[k] - qe[k] * DEN;
        negc_r[k] <= negb_r[k];
      end
    end
  end

  logic [BAM_W-1:0] bam_r [3];
  logic [63:0] qf [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qf[k] = qe_r[k];
      for (int j = 1; j <= 4; j++)
        if (re_r[k] >= 64'(j) * DEN) qf[k] = qf[k] + 64'd1;
    end
  end
  logic flip_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [BAM_W-1:0] a;
        logic fl;
        a = negc_r[k] ? BAM_W'(-qf[k]) : BAM_W'(qf[k]);
        fl = (a - QUARTER_TURN) < HALF_TURN;
        flip_r[k] <= fl;
        bam_r[k] <= fl ? a - HALF_TURN : a;
      end
    end
  end

  // Sine/cosine cell rows, three lanes.
  sval_t rx [3][N+1];
  sval_t ry [3][N+1];
  logic signed [ZW-1:0] rz [3][N+1];
  logic flp [3][N+1];
  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign rx[k][0] = GAIN_Q30;
    assign ry[k][0] = '0;
    assign rz[k][0] = ZW'(signed'(bam_r[k]));
    assign flp[k][0] = flip_r[k];
    for (genvar s = 0; s < N; s++) begin : g_cell
      ibcp_rot_cell #(.STAGE(s)) u_cell (
        .clk(clk), .en(en), .x_in(rx[k][s]), .y_in(ry[k][s]), .z_in(rz[k][s]),
        .x_r(rx[k][s+1]), .y_r(ry[k][s+1]), .z_r(rz[k][s+1])
      );
      always_ff @(posedge clk) if (en) flp[k][s+1] <= flp[k][s];
    end
  end

  // Product stages.
  sval_t s1_r, c1_r, s2_r, c2_r, sd_r, cd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= flp[0][N] ? -ry[0][N] : ry[0][N];
      c1_r <= flp[0][N] ? -rx[0][N] : rx[0][N];
      s2_r <= flp[1][N] ? -ry[1][N] : ry[1][N];
      c2_r <= flp[1][N] ? -rx[1][N] : rx[1][N];
      sd_r <= flp[2][N] ? -ry[2][N] : ry[2][N];
      cd_r <= flp[2][N] ? -rx[2][N] : rx[2][N];
    end
  end
  logic signed [67:0] p_ny_r, p_t_r, p_a_r;
  sval_t cd2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_ny_r <= 68'(sd_r) * 68'(c2_r);
      p_t_r  <= 68'(s1_r) * 68'(c2_r);
      p_a_r  <= 68'(c1_r) * 68'(s2_r);
      cd2_r  <= cd_r;
    end
  end
  sval_t ny_r, t_r, a_r, cd3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ny_r  <= DW'(p_ny_r >>> Q30_SHIFT);
      t_r   <= DW'(p_t_r >>> Q30_SHIFT);
      a_r   <= DW'(p_a_r >>> Q30_SHIFT);
      cd3_r <= cd2_r;
    end
  end
  logic signed [67:0] p_b_r;
  sval_t ny4_r, a4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_b_r <= 68'(t_r) * 68'(cd3_r);
      ny4_r <= ny_r;
      a4_r  <= a_r;
    end
  end
  sval_t nx5;
  assign nx5 = a4_r - DW'(p_b_r >>> Q30_SHIFT);
  sval_t vx [N+1];
  sval_t vy [N+1];
  logic [BAM_W-1:0] vz [N+1];
  logic dg [N+1];
  always_ff @(posedge clk) begin
    if (en) begin
      dg[0] <= (nx5 == '0) && (ny4_r == '0);
      vx[0] <= nx5[DW-1] ? -nx5 : nx5;
      vy[0] <= nx5[DW-1] ? -ny4_r : ny4_r;
      vz[0] <= nx5[DW-1] ? HALF_TURN : '0;
    end
  end
  for (genvar s = 0; s < N; s++) begin : g_vec
    ibcp_vec_cell #(.STAGE(s)) u_cell (
      .clk(clk), .en(en), .x_in(vx[s]), .y_in(vy[s]), .z_in(vz[s]),
      .x_r(vx[s+1]), .y_r(vy[s+1]), .z_r(vz[s+1])
    );
    always_ff @(posedge clk) if (en) dg[s+1] <= dg[s];
  end

  // Bearing scaling and sector.
  logic [BRG_W:0] b_r;
  logic dgb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      b_r <= (BRG_W+1)'(((64'(vz[N]) * 64'd360) + (64'd1 << (31 - F))) >> (32 - F));
      dgb_r <= dg[N];
    end
  end
  logic [BRG_W-1:0] brg_r;
  always_ff @(posedge clk) begin
    if (en) brg_r <= dgb_r ? '0 : (b_r >= (BRG_W+1)'(FULL) ? BRG_W'(b_r - FULL) : BRG_W'(b_r));
  end
  logic [BRG_W-1:0] bo_r;
  logic [SECT_W-1:0] so_r;
  logic [SECT_W-1:0] sc;
  always_comb begin
    sc = '0;
    for (int k = 1; k < 16; k++)
      if (64'(brg_r) * 64'd2 >= 64'(SECT) * 64'(k)) sc = SECT_W'(k);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bo_r <= brg_r;
      so_r <= sc;
    end
  end
  assign out_ch.bearing = bo_r;
  assign out_ch.compass_sector = so_r;
endmodule
`default_nettype wire
